/* hw/rtl/lsoc_pkg.sv */
// Shared types and constants for the line segment overlap counter.
// No dependencies; imported by the core.
package lsoc_pkg;

  localparam int unsigned COORD_W   = 10;
  localparam int unsigned TOTAL_W   = 21;
  localparam int unsigned HIT_W     = 2;
  localparam int unsigned STEP_W    = COORD_W;

  localparam logic [HIT_W-1:0]   HIT_LIMIT = HIT_W'(2);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [HIT_W-1:0]   hit_t;

  // Walk direction of one axis
  typedef struct packed {
    logic inc;
    logic dec;
  } axis_dir_t;

  // Saturating hit counter update
  function automatic hit_t hit_next(input hit_t cur);
    hit_t res;
    res = cur;
    if (cur < HIT_LIMIT) begin
      res = cur + hit_t'(1);
    end
    return res;
  endfunction

  function automatic coord_t step_coord(input coord_t c, input axis_dir_t d);
    coord_t res;
    res = c;
    if (d.inc) begin
      res = c + coord_t'(1);
    end else if (d.dec) begin
      res = c - coord_t'(1);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/lsoc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lsoc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/line_segment_overlap_counter_core.sv */
// Line segment overlap counter: rasterises each segment into a grid of hit counters.
// A rejected segment's result strobe is registered at the start transfer; an accepted segment
// of n cells is walked in ST_WALK, one cell read-modify-write per cycle, then ST_DRAIN writes
// back the last cell and registers the strobe. A new start is taken in the strobe cycle; no new
// segment is taken while one is walked. The receiver cannot stall. Reset: asynchronous, active
// low; a clearing pass of all GRID_SIDE*GRID_SIDE cells holds busy high. Uses lsoc_pkg, lsoc_ram.
module line_segment_overlap_counter_core
  import lsoc_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] x_start_i,
  input  logic [COORD_W-1:0] y_start_i,
  input  logic [COORD_W-1:0] x_end_i,
  input  logic [COORD_W-1:0] y_end_i,
  output logic               done_o,
  output logic [TOTAL_W-1:0] overlap_total_o,
  output logic               bad_segment_o
);

  localparam int unsigned DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  coord_t          x_q, y_q;
  axis_dir_t       dir_x_q, dir_y_q;
  logic [STEP_W-1:0] rem_q;
  logic            pend_q;
  logic [AW-1:0]   pend_addr_q;
  total_t          count_q;
  logic            done_q;
  total_t          total_q;
  logic            bad_q;

  // Segment classification at the start transfer
  logic              accept;
  logic              off_grid;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0] adx, ady;
  logic              slanted;
  logic              bad_in;

  assign accept   = start && !busy;
  assign off_grid = (int'(x_start_i) >= GRID_SIDE) || (int'(y_start_i) >= GRID_SIDE) ||
                    (int'(x_end_i) >= GRID_SIDE)   || (int'(y_end_i) >= GRID_SIDE);
  assign dx       = $signed({1'b0, x_end_i}) - $signed({1'b0, x_start_i});
  assign dy       = $signed({1'b0, y_end_i}) - $signed({1'b0, y_start_i});
  assign adx      = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady      = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign slanted  = (adx != '0) && (ady != '0) && (adx != ady);
  assign bad_in   = off_grid || slanted;

  // Grid address of the current cell
  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(AW'(y_q) * AW'(GRID_SIDE)) + AW'(x_q);

  // Read-modify-write of the pending cell
  hit_t          rdata;
  hit_t          hit_upd;
  logic          reach_two;
  total_t        count_inc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  hit_t          ram_wdata;

  assign hit_upd   = hit_next(rdata);
  assign reach_two = pend_q && (rdata != HIT_LIMIT) && (hit_upd == HIT_LIMIT);
  assign count_inc = (reach_two && (count_q != TOTAL_MAX)) ? count_q + total_t'(1) : count_q;

  always_comb begin
    ram_we    = pend_q;
    ram_waddr = pend_addr_q;
    ram_wdata = hit_upd;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end
  end

  lsoc_ram #(
    .WIDTH(HIT_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // Sequencer: clearing pass, cell walk, drain and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      done_q      <= 1'b0;
      total_q     <= '0;
      bad_q       <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      rem_q       <= '0;
      pend_addr_q <= '0;
    end else begin
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
      count_q <= count_inc;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (bad_in) begin
              done_q  <= 1'b1;
              bad_q   <= 1'b1;
              total_q <= count_q;
            end else begin
              state_q     <= ST_WALK;
              x_q         <= x_start_i;
              y_q         <= y_start_i;
              dir_x_q.inc <= !dx[COORD_W] && (dx != '0);
              dir_x_q.dec <= dx[COORD_W];
              dir_y_q.inc <= !dy[COORD_W] && (dy != '0);
              dir_y_q.dec <= dy[COORD_W];
              rem_q       <= (adx > ady) ? adx : ady;
            end
          end
        end
        ST_WALK: begin
          pend_q      <= 1'b1;
          pend_addr_q <= rd_addr;
          x_q         <= step_coord(x_q, dir_x_q);
          y_q         <= step_coord(y_q, dir_y_q);
          rem_q       <= rem_q - STEP_W'(1);
          if (rem_q == '0) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          bad_q   <= 1'b0;
          total_q <= count_inc;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign overlap_total_o = total_q;
  assign bad_segment_o   = bad_q;

`ifndef SYNTHESIS
  // Every start transfer leads straight to a result or to the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("start transfer neither answered nor walked");

  // A result is only shown while the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A rejected segment leaves the running total unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_segment_o) |-> $stable(overlap_total_o))
    else $error("rejected segment changed the total");

  // During the walk the write-back never hits the cell being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && (state_q == ST_WALK)) |-> (pend_addr_q != rd_addr))
    else $error("read-modify-write hazard on grid RAM");
`endif

endmodule

/* tb/tb_line_segment_overlap_counter_core.sv */
// Self-checking testbench for line_segment_overlap_counter_core: directed table then random
// segments, checked against an in-bench rasteriser or typed totals. Depends on lsoc_pkg.
`timescale 1ns / 100ps

module tb_line_segment_overlap_counter_core;
  import lsoc_pkg::*;

  localparam int unsigned GRID_SIDE     = 1024;
  localparam int          RANDOM_ITEMS  = 560;
  localparam int          CLUSTER_SPAN  = 48;
  localparam int          SHORT_CAP     = 15;
  // clearing pass plus ~600 worst-case segments, taken about five times over
  localparam int          RUN_LIMIT_CYCLES = 8_000_000;
  localparam int          PRINT_CAP     = 200;

  typedef struct {
    total_t total;
    logic   bad;
  } overlap_result_t;

  typedef struct {
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    bit     typed;
    total_t total;
    logic   bad;
  } segment_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t x_start_i;
  coord_t y_start_i;
  coord_t x_end_i;
  coord_t y_end_i;
  logic   done_o;
  total_t overlap_total_o;
  logic   bad_segment_o;

  // Predicted grid: sparse, a missing cell has never been hit
  hit_t            grid_hits [int unsigned];
  total_t          overlap_running;
  overlap_result_t pending_results [$];
  int              mismatch_count;
  int              results_seen;
  int              cluster_x;
  int              cluster_y;

  // Eight walk directions: horizontal, vertical and both diagonals
  int walk_dx [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
  int walk_dy [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  // Directed rows; totals typed in only where they follow directly from the rows above
  segment_row_t directed_rows [22] = '{
    '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 21'd0,    1'b0}, // single point
    '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 21'd1,    1'b0}, // same point twice
    '{10'd0,    10'd0,    10'd1,    10'd2,    1'b1, 21'd1,    1'b1}, // slanted
    '{10'd0,    10'd0,    10'd1023, 10'd0,    1'b1, 21'd1,    1'b0}, // full row
    '{10'd1023, 10'd0,    10'd0,    10'd0,    1'b1, 21'd1024, 1'b0}, // same row reversed
    '{10'd1023, 10'd1023, 10'd0,    10'd1022, 1'b1, 21'd1024, 1'b1}, // slanted, long
    '{10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd1024, 1'b0}, // full diagonal
    '{10'd1023, 10'd1023, 10'd0,    10'd0,    1'b1, 21'd2047, 1'b0}, // diagonal reversed
    '{10'd1023, 10'd0,    10'd0,    10'd1023, 1'b1, 21'd2047, 1'b0}, // anti-diagonal
    '{10'd0,    10'd1023, 10'd1023, 10'd0,    1'b0, 21'd0,    1'b0},
    '{10'd1023, 10'd0,    10'd1023, 10'd1023, 1'b0, 21'd0,    1'b0}, // right column
    '{10'd0,    10'd1023, 10'd0,    10'd0,    1'b0, 21'd0,    1'b0}, // left column upward
    '{10'd1023, 10'd1023, 10'd0,    10'd1023, 1'b0, 21'd0,    1'b0}, // top row reversed
    '{10'd1023, 10'd0,    10'd0,    10'd1,    1'b0, 21'd0,    1'b1}, // slanted, shallow
    '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 21'd0,    1'b0}, // corner point
    '{10'd20,   10'd30,   10'd10,   10'd20,   1'b0, 21'd0,    1'b0},
    '{10'd10,   10'd30,   10'd20,   10'd20,   1'b0, 21'd0,    1'b0},
    '{10'd15,   10'd10,   10'd15,   10'd40,   1'b0, 21'd0,    1'b0},
    '{10'd5,    10'd25,   10'd40,   10'd25,   1'b0, 21'd0,    1'b0},
    '{10'd100,  10'd100,  10'd110,  10'd111,  1'b0, 21'd0,    1'b1}, // one off 45 degrees
    '{10'd512,  10'd512,  10'd513,  10'd514,  1'b0, 21'd0,    1'b1},
    '{10'd15,   10'd25,   10'd15,   10'd25,   1'b0, 21'd0,    1'b0}  // fifth hit, saturated
  };

  line_segment_overlap_counter_core #(
    .GRID_SIDE(GRID_SIDE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .done_o         (done_o),
    .overlap_total_o(overlap_total_o),
    .bad_segment_o  (bad_segment_o)
  );

  always #5 clk_i = ~clk_i;

  // One line per mismatch; printing capped so a broken block cannot flood the log
  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Rasterise one segment into the predicted grid and return the running total
  function automatic overlap_result_t rasterise_segment(input coord_t xs, input coord_t ys,
                                                        input coord_t xe, input coord_t ye);
    overlap_result_t res;
    int          dx;
    int          dy;
    int          adx;
    int          ady;
    int          sx;
    int          sy;
    int          cells;
    int          x;
    int          y;
    int unsigned idx;
    hit_t        hits;
    dx  = int'(xe) - int'(xs);
    dy  = int'(ye) - int'(ys);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    res.bad = (int'(xs) >= GRID_SIDE) || (int'(ys) >= GRID_SIDE) ||
              (int'(xe) >= GRID_SIDE) || (int'(ye) >= GRID_SIDE) ||
              (dx != 0 && dy != 0 && adx != ady);
    if (!res.bad) begin
      sx    = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      sy    = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      cells = ((adx > ady) ? adx : ady) + 1;
      x     = int'(xs);
      y     = int'(ys);
      for (int i = 0; i < cells; i++) begin
        idx  = x + y * GRID_SIDE;
        hits = grid_hits.exists(idx) ? grid_hits[idx] : '0;
        if (hits < HIT_LIMIT) begin
          hits           = hits + hit_t'(1);
          grid_hits[idx] = hits;
          if (hits == HIT_LIMIT && overlap_running != TOTAL_MAX) begin
            overlap_running = overlap_running + total_t'(1);
          end
        end
        x += sx;
        y += sy;
      end
    end
    res.total = overlap_running;
    return res;
  endfunction

  // Present a segment and hold it until the start transfer; queue what it should return
  task automatic issue_segment(input coord_t xs, input coord_t ys, input coord_t xe,
                               input coord_t ye, input bit typed, input total_t typed_total,
                               input logic typed_bad);
    overlap_result_t predicted;
    start     <= 1'b1;
    x_start_i <= xs;
    y_start_i <= ys;
    x_end_i   <= xe;
    y_end_i   <= ye;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = rasterise_segment(xs, ys, xe, ye);
    if (typed) begin
      predicted.total = typed_total;
      predicted.bad   = typed_bad;
    end
    pending_results.push_back(predicted);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic idle_gap(input bit allow);
    int gap;
    gap = allow ? int'($urandom_range(10)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random segment: mostly short well-formed ones in a cluster, some long ones, some slanted
  task automatic pick_segment(output coord_t xs, output coord_t ys, output coord_t xe,
                              output coord_t ye);
    int kind;
    int dir;
    int room;
    int cap;
    int len;
    int x0;
    int y0;
    kind = $urandom_range(99);
    if (kind < 85) begin
      dir = $urandom_range(7);
      if (kind < 80) begin
        x0  = cluster_x + int'($urandom_range(CLUSTER_SPAN - 1));
        y0  = cluster_y + int'($urandom_range(CLUSTER_SPAN - 1));
        cap = SHORT_CAP;
      end else begin
        x0  = $urandom_range(GRID_SIDE - 1);
        y0  = $urandom_range(GRID_SIDE - 1);
        cap = GRID_SIDE - 1;
      end
      room = cap;
      if (walk_dx[dir] > 0 && GRID_SIDE - 1 - x0 < room) room = GRID_SIDE - 1 - x0;
      if (walk_dx[dir] < 0 && x0 < room) room = x0;
      if (walk_dy[dir] > 0 && GRID_SIDE - 1 - y0 < room) room = GRID_SIDE - 1 - y0;
      if (walk_dy[dir] < 0 && y0 < room) room = y0;
      len = $urandom_range(room);
      xs  = coord_t'(x0);
      ys  = coord_t'(y0);
      xe  = coord_t'(x0 + walk_dx[dir] * len);
      ye  = coord_t'(y0 + walk_dy[dir] * len);
    end else if (kind < 93) begin
      xs = coord_t'($urandom_range(GRID_SIDE - 1));
      ys = coord_t'($urandom_range(GRID_SIDE - 1));
      xe = coord_t'($urandom_range(GRID_SIDE - 1));
      ye = coord_t'($urandom_range(GRID_SIDE - 1));
    end else begin
      // near miss inside the cluster: one column across, two rows across
      xs = coord_t'(cluster_x + int'($urandom_range(CLUSTER_SPAN - 1)));
      ys = coord_t'(cluster_y + int'($urandom_range(CLUSTER_SPAN - 1)));
      xe = xs ^ coord_t'(1);
      ye = ys ^ coord_t'(2);
    end
  endtask

  // Result checker: every strobe is a transfer, compared with the oldest expectation
  always @(posedge clk_i) begin : check_results
    overlap_result_t exp_res;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected (total %0d bad %0b)",
                                results_seen, overlap_total_o, bad_segment_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (overlap_total_o !== exp_res.total) begin
          flag_mismatch($sformatf("result %0d overlap_total %0d, expected %0d",
                                  results_seen, overlap_total_o, exp_res.total));
        end
        if (bad_segment_o !== exp_res.bad) begin
          flag_mismatch($sformatf("result %0d bad_segment %0b, expected %0b",
                                  results_seen, bad_segment_o, exp_res.bad));
        end
      end
    end
  end

  // Stimulus
  initial begin : drive_segments
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    rst_ni          = 1'b0;
    start           = 1'b0;
    x_start_i       = '0;
    y_start_i       = '0;
    x_end_i         = '0;
    y_end_i         = '0;
    overlap_running = '0;
    mismatch_count  = 0;
    results_seen    = 0;
    cluster_x       = 0;
    cluster_y       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; busy covers the clearing pass
    foreach (directed_rows[i]) begin
      issue_segment(directed_rows[i].xs, directed_rows[i].ys, directed_rows[i].xe,
                    directed_rows[i].ye, directed_rows[i].typed, directed_rows[i].total,
                    directed_rows[i].bad);
      idle_gap(i % 2 == 1);
    end
    drain_results();

    // random part; every third run of 40 items goes back to back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        cluster_x = $urandom_range(GRID_SIDE - CLUSTER_SPAN);
        cluster_y = $urandom_range(GRID_SIDE - CLUSTER_SPAN);
      end
      pick_segment(xs, ys, xe, ye);
      issue_segment(xs, ys, xe, ye, 1'b0, '0, 1'b0);
      if (i % 97 == 96) begin
        drain_results();
      end else begin
        idle_gap((i / 40) % 3 != 0);
      end
    end

    drain_results();
    repeat (GRID_SIDE + 4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : run_limit
    repeat (RUN_LIMIT_CYCLES) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lsoc_pkg.sv
hw/rtl/lsoc_ram.sv
hw/rtl/line_segment_overlap_counter_core.sv
tb/tb_line_segment_overlap_counter_core.sv
